// ----- sv/k_nearest_sorted_insert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef K_NEAREST_SORTED_INSERT_MACROS_SVH
`define K_NEAREST_SORTED_INSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KNSI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KNSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/knsi_pkg.sv -----
package knsi_pkg;

   localparam int MAX_SLOTS_DEFAULT = 8;
   localparam int DIST_BITS_DEFAULT = 32;
   localparam int K_LIMIT_BITS      = 4;

   localparam logic [K_LIMIT_BITS-1:0] K_LIMIT_RESET = 4'd8;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef logic [9:0]  source_type;
   typedef logic [15:0] instance_type;

   // Request payload
   typedef struct packed {
      logic         kind;
      logic [31:0]  distance;
      source_type   source_id;
      instance_type instance_index;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [2:0]   rank;
      logic         filled;
      logic [31:0]  slot_distance;
      source_type   slot_source;
      instance_type slot_instance;
      logic         last;
   } rsp_type;

   // Per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;
      logic shift_up;
   } cell_ctrl_type;

   // Flush sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic shift_up;
   } flush_status_type;

   typedef enum logic {
      FLUSH_IDLE,
      FLUSH_RUN
   } flush_state_type;

endpackage

// ----- sv/knsi_cell.sv -----
module knsi_cell #(
   parameter int DIST_BITS = 32
) (
   input  logic                   clock,
   input  knsi_pkg::cell_ctrl_type ctrl,
   input  logic                   live,
   input  logic [DIST_BITS-1:0]   new_dist,
   input  knsi_pkg::source_type   new_src,
   input  knsi_pkg::instance_type new_inst,
   input  logic                   prev_lt,
   input  logic [DIST_BITS-1:0]   prev_dist,
   input  knsi_pkg::source_type   prev_src,
   input  knsi_pkg::instance_type prev_inst,
   input  logic [DIST_BITS-1:0]   next_dist,
   input  knsi_pkg::source_type   next_src,
   input  knsi_pkg::instance_type next_inst,
   output logic                   lt,
   output logic [DIST_BITS-1:0]   cur_dist,
   output knsi_pkg::source_type   src,
   output knsi_pkg::instance_type inst
);
   import knsi_pkg::*;

   logic [DIST_BITS-1:0] dist_ff, dist_in;
   source_type           src_ff, src_in;
   instance_type         inst_ff, inst_in;

   // Held entry ranks ahead of the new candidate
   assign lt = live && (dist_ff < new_dist);

   // Keep, take the candidate, take the left neighbor, or advance toward the head
   always_comb begin
      priority if (ctrl.shift_up) begin
         dist_in = next_dist;
         src_in  = next_src;
         inst_in = next_inst;
      end else if (ctrl.insert && !lt) begin
         if (prev_lt) begin
            dist_in = new_dist;
            src_in  = new_src;
            inst_in = new_inst;
         end else begin
            dist_in = prev_dist;
            src_in  = prev_src;
            inst_in = prev_inst;
         end
      end else begin
         dist_in = dist_ff;
         src_in  = src_ff;
         inst_in = inst_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      src_ff  <= src_in;
      inst_ff <= inst_in;
   end

   assign cur_dist = dist_ff;
   assign src      = src_ff;
   assign inst     = inst_ff;

endmodule

// ----- sv/knsi_flush.sv -----
module knsi_flush #(
   parameter int MAX_SLOTS = 8,
   parameter int DIST_BITS = 32,
   localparam int CW = $clog2(MAX_SLOTS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [CW-1:0]              count,
   input  logic [DIST_BITS-1:0]       head_dist,
   input  knsi_pkg::source_type       head_src,
   input  knsi_pkg::instance_type     head_inst,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output knsi_pkg::rsp_type          rsp_data,
   output knsi_pkg::flush_status_type status
);
   import knsi_pkg::*;

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [IW-1:0] LAST_BEAT = IW'(MAX_SLOTS - 1);

   flush_state_type state_ff, state_in;
   logic [IW-1:0]   beat_ff, beat_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            valid_ff, valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            load;
   logic            filled;

   // Build the result for the current beat from the chain head
   assign filled = CW'(beat_ff) < fill_ff;

   always_comb begin
      rsp_in.rank          = 3'(beat_ff);
      rsp_in.filled        = filled;
      rsp_in.slot_distance = filled ? 32'(head_dist) : '0;
      rsp_in.slot_source   = filled ? head_src : '0;
      rsp_in.slot_instance = filled ? head_inst : '0;
      rsp_in.last          = (beat_ff == LAST_BEAT);
   end

   // Next state, beat counter and output register load
   always_comb begin
      state_in = state_ff;
      beat_in  = beat_ff;
      fill_in  = fill_ff;
      valid_in = valid_ff && rsp_stall;
      load     = 1'b0;
      unique case (state_ff)
         FLUSH_IDLE: begin
            if (start) begin
               state_in = FLUSH_RUN;
               beat_in  = '0;
               fill_in  = count;
            end
         end
         FLUSH_RUN: begin
            if (!valid_ff || !rsp_stall) begin
               load     = 1'b1;
               valid_in = 1'b1;
               if (beat_ff == LAST_BEAT) begin
                  state_in = FLUSH_IDLE;
               end else begin
                  beat_in = IW'(beat_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = FLUSH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FLUSH_IDLE;
         beat_ff  <= '0;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.busy     = (state_ff == FLUSH_RUN);
   assign status.shift_up = load;

endmodule

// ----- sv/k_nearest_sorted_insert.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  knsi_pkg::req_type (insert or flush)
// rsp       out        rsp_valid/rsp_stall  knsi_pkg::rsp_type (one slot per result)
// csr       in         csr_wr_en            csr_wr_data (k_limit)
//
// Inserts can be accepted on every cycle while no flush is running.
// A flush stalls requests while the cell chain shifts toward the head,
// one slot per result, and for longer when rsp_stall holds results.
// Reset sets k_limit to 8 and empties the list; slot contents are not cleared.
// The result register lets the next request enter while the last result waits.
module k_nearest_sorted_insert #(
   parameter int MAX_SLOTS = knsi_pkg::MAX_SLOTS_DEFAULT,
   parameter int DIST_BITS = knsi_pkg::DIST_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  knsi_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output knsi_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [knsi_pkg::K_LIMIT_BITS-1:0]       csr_wr_data
);
   import knsi_pkg::*;

   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic [K_LIMIT_BITS-1:0] k_limit_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           k_eff;
   logic [CW-1:0]           held;
   logic [IW-1:0]           k_idx;
   logic                    insert_acc;
   logic                    flush_acc;
   logic                    discard;
   logic [DIST_BITS-1:0]    new_dist;
   cell_ctrl_type           ctrl;
   flush_status_type        status;

   logic [MAX_SLOTS-1:0]    lt;
   logic [DIST_BITS-1:0]    cell_dist [MAX_SLOTS];
   source_type              cell_src  [MAX_SLOTS];
   instance_type            cell_inst [MAX_SLOTS];

   // Write the limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         k_limit_ff <= K_LIMIT_RESET;
      end else if (csr_wr_en) begin
         k_limit_ff <= csr_wr_data;
      end
   end

   // Clamp the limit to 1..MAX_SLOTS and the held count to the limit
   always_comb begin
      priority if (k_limit_ff == '0) begin
         k_eff = CW'(1);
      end else if (k_limit_ff > MAX_SLOTS) begin
         k_eff = CW'(MAX_SLOTS);
      end else begin
         k_eff = CW'(k_limit_ff);
      end
   end

   assign held  = (count_ff > k_eff) ? k_eff : count_ff;
   assign k_idx = IW'(k_eff - 1'b1);

   // Accept requests only while no flush is running
   assign req_stall  = status.busy;
   assign insert_acc = req_valid && !req_stall && (req_data.kind == KIND_INSERT);
   assign flush_acc  = req_valid && !req_stall && (req_data.kind == KIND_FLUSH);
   assign new_dist   = DIST_BITS'(req_data.distance);

   // A full list whose entries all rank ahead drops the candidate
   assign discard = (held == k_eff) && lt[k_idx];

   always_comb begin
      priority if (flush_acc) begin
         count_in = '0;
      end else if (insert_acc) begin
         if (discard) begin
            count_in = held;
         end else if (held == k_eff) begin
            count_in = k_eff;
         end else begin
            count_in = CW'(held + 1'b1);
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign ctrl.insert   = insert_acc;
   assign ctrl.shift_up = status.shift_up;

   // Chain of slot cells, rank 0 at the head
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      logic                 prev_lt;
      logic [DIST_BITS-1:0] prev_dist, next_dist;
      source_type           prev_src, next_src;
      instance_type         prev_inst, next_inst;

      if (i == 0) begin : g_head
         assign prev_lt   = 1'b1;
         assign prev_dist = new_dist;
         assign prev_src  = req_data.source_id;
         assign prev_inst = req_data.instance_index;
      end else begin : g_body
         assign prev_lt   = lt[i-1];
         assign prev_dist = cell_dist[i-1];
         assign prev_src  = cell_src[i-1];
         assign prev_inst = cell_inst[i-1];
      end

      if (i == MAX_SLOTS - 1) begin : g_tail
         assign next_dist = '0;
         assign next_src  = '0;
         assign next_inst = '0;
      end else begin : g_inner
         assign next_dist = cell_dist[i+1];
         assign next_src  = cell_src[i+1];
         assign next_inst = cell_inst[i+1];
      end

      knsi_cell #(
         .DIST_BITS(DIST_BITS)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .live     (held > CW'(i)),
         .new_dist (new_dist),
         .new_src  (req_data.source_id),
         .new_inst (req_data.instance_index),
         .prev_lt  (prev_lt),
         .prev_dist(prev_dist),
         .prev_src (prev_src),
         .prev_inst(prev_inst),
         .next_dist(next_dist),
         .next_src (next_src),
         .next_inst(next_inst),
         .lt       (lt[i]),
         .cur_dist (cell_dist[i]),
         .src      (cell_src[i]),
         .inst     (cell_inst[i])
      );
   end

   // Drain the chain head into the result register on flush
   knsi_flush #(
      .MAX_SLOTS(MAX_SLOTS),
      .DIST_BITS(DIST_BITS)
   ) u_flush (
      .clock    (clock),
      .reset    (reset),
      .start    (flush_acc),
      .count    (count_ff),
      .head_dist(cell_dist[0]),
      .head_src (cell_src[0]),
      .head_inst(cell_inst[0]),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .status   (status)
   );

endmodule

// ----- sv/knsi_checker.sv -----
`include "k_nearest_sorted_insert_macros.svh"

module knsi_checker #(
   parameter int MAX_SLOTS = knsi_pkg::MAX_SLOTS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input knsi_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input knsi_pkg::rsp_type                 rsp_data
);
   import knsi_pkg::*;

   // Stalled result stays put
   `KNSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Flush blocks further requests in the following cycle
   `KNSI_ASSERT_NEXT(a_flush_stall, clock, reset, req_valid && !req_stall && (req_data.kind == KIND_FLUSH), req_stall, "request taken during flush")

   // Empty slots read as zero
   `KNSI_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_data.filled, (rsp_data.slot_distance == '0) && (rsp_data.slot_source == '0) && (rsp_data.slot_instance == '0), "empty slot not zero")

   // Last result carries the final rank
   `KNSI_ASSERT_NOW(a_last_rank, clock, reset, rsp_valid && rsp_data.last, rsp_data.rank == 3'(MAX_SLOTS - 1), "last flag on wrong rank")

endmodule

bind k_nearest_sorted_insert knsi_checker #(.MAX_SLOTS(MAX_SLOTS)) u_knsi_checker (.*);
